FILE: src/assert_macros.svh
// Assertion macros shared by the combination generator RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed in %m");
`define ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition in %m");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

FILE: src/ncg_pkg.sv
// Shared types and constants of the combination generator.
// Used by the controller, the datapath and the top level.
package ncg_pkg;

   localparam int N_W   = 6;
   localparam int K_W   = 5;
   localparam int POS_W = 4;
   localparam int IDX_W = 1;
   localparam int CSR_W = 6;

   localparam logic [IDX_W-1:0] REG_SET_SIZE    = 1'd0;
   localparam logic [IDX_W-1:0] REG_SUBSET_SIZE = 1'd1;

   localparam logic [N_W-1:0] SET_SIZE_RST    = 6'd5;
   localparam logic [K_W-1:0] SUBSET_SIZE_RST = 5'd3;

   typedef struct packed {
      logic load_first;
      logic search_init;
      logic read;
      logic search_step;
      logic search_dec;
      logic emit_init;
      logic emit;
      logic emit_exh;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic below;
      logic cnt_zero;
      logic cnt_last;
      logic out_free;
   } sts_type;

endpackage

FILE: src/ncg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ncg_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       re,
   input  logic [ADDR_W-1:0]          raddr,
   output logic [WIDTH-1:0]           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/ncg_ctrl.sv
// Controller of the combination generator: request handshake and sequencing.
// Depends on ncg_pkg for the command and status structs.
module ncg_ctrl
   import ncg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_restart,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_EXH,
      S_SRD,
      S_SCMP,
      S_ERD,
      S_EOUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load_first = req_restart;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.invalid) begin
               state_in = S_EXH;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = S_SRD;
            end
         end
         S_EXH: begin
            if (sts.out_free) begin
               cmd.emit_exh = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SRD: begin
            cmd.read = 1'b1;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            cmd.search_step = 1'b1;
            if (sts.below || sts.cnt_zero) begin
               cmd.emit_init = 1'b1;
               state_in      = S_ERD;
            end else begin
               cmd.search_dec = 1'b1;
               state_in       = S_SRD;
            end
         end
         S_ERD: begin
            cmd.read = 1'b1;
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.cnt_last ? S_IDLE : S_ERD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = req_ready_ff;
endmodule

FILE: src/ncg_dpath.sv
// Datapath of the combination generator: config, element store, search and output beat.
// Depends on ncg_pkg, ncg_ram and assert_macros.svh.
`include "assert_macros.svh"
module ncg_dpath
   import ncg_pkg::*;
#(
   parameter int MAX_K = 16,
   parameter int MAX_N = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [N_W-1:0]    rsp_element,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_last,
   output logic              rsp_final_combination,
   output logic              rsp_exhausted
);
   localparam int ADDR_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam logic [7:0] MAX_K_V = 8'(MAX_K);
   localparam logic [8:0] MAX_N_V = 9'(MAX_N);

   logic [N_W-1:0]    n_ff;
   logic [K_W-1:0]    k_ff;
   logic [MAX_K-1:0]  valid_ff;
   logic              done_ff;
   logic [K_W-1:0]    cnt_ff;
   logic              found_ff;
   logic [K_W-1:0]    pivot_ff;
   logic [N_W-1:0]    run_ff;

   logic              rsp_valid_ff;
   logic [N_W-1:0]    rsp_element_ff;
   logic [POS_W-1:0]  rsp_position_ff;
   logic              rsp_last_ff;
   logic              rsp_final_ff;
   logic              rsp_exhausted_ff;

   logic [ADDR_W-1:0] addr;
   logic [N_W-1:0]    rdata;
   logic [N_W-1:0]    eff;
   logic [7:0]        limit;
   logic              ram_we;
   logic [N_W-1:0]    wdata;
   logic              load_out;

   assign addr  = ADDR_W'(cnt_ff);
   assign eff   = valid_ff[addr] ? rdata : (N_W'(cnt_ff) + 6'd1);
   assign limit = {2'b00, n_ff} - {3'b000, k_ff} + {3'b000, cnt_ff} + 8'd1;

   assign ram_we   = cmd.emit && found_ff && (cnt_ff >= pivot_ff);
   assign wdata    = (cnt_ff == pivot_ff) ? (eff + 6'd1) : (run_ff + 6'd1);
   assign load_out = cmd.emit || cmd.emit_exh;

   assign sts.invalid  = (k_ff == '0) || ({3'b000, k_ff} > MAX_K_V)
                         || ({1'b0, k_ff} > n_ff) || ({3'b000, n_ff} > MAX_N_V)
                         || done_ff;
   assign sts.below    = ({2'b00, eff} < limit);
   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.cnt_last = (cnt_ff == (k_ff - 5'd1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   ncg_ram #(
      .WIDTH (N_W),
      .DEPTH (MAX_K)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr),
      .wdata (wdata),
      .re    (cmd.read),
      .raddr (addr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= SET_SIZE_RST;
         k_ff         <= SUBSET_SIZE_RST;
         valid_ff     <= '0;
         done_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SET_SIZE:    n_ff <= csr_data;
               REG_SUBSET_SIZE: k_ff <= csr_data[K_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load_first) begin
            valid_ff <= '0;
            done_ff  <= 1'b0;
         end
         if (cmd.search_init) begin
            found_ff <= 1'b0;
         end
         if (cmd.search_step && sts.below) begin
            found_ff <= 1'b1;
         end
         if (ram_we) begin
            valid_ff[addr] <= 1'b1;
         end
         if (cmd.emit && sts.cnt_last && !found_ff) begin
            done_ff <= 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         cnt_ff <= k_ff - 5'd1;
      end else if (cmd.emit_init) begin
         cnt_ff <= '0;
      end else if (cmd.search_dec) begin
         cnt_ff <= cnt_ff - 5'd1;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.search_step && sts.below) begin
         pivot_ff <= cnt_ff;
      end
      if (ram_we) begin
         run_ff <= wdata;
      end
      if (cmd.emit) begin
         rsp_element_ff   <= eff;
         rsp_position_ff  <= cnt_ff[POS_W-1:0];
         rsp_last_ff      <= sts.cnt_last;
         rsp_final_ff     <= !found_ff;
         rsp_exhausted_ff <= 1'b0;
      end else if (cmd.emit_exh) begin
         rsp_element_ff   <= '0;
         rsp_position_ff  <= '0;
         rsp_last_ff      <= 1'b1;
         rsp_final_ff     <= 1'b0;
         rsp_exhausted_ff <= 1'b1;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_element           = rsp_element_ff;
   assign rsp_position          = rsp_position_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_final_combination = rsp_final_ff;
   assign rsp_exhausted         = rsp_exhausted_ff;

   `ASSERT_NEVER(a_load_over_full, load_out && rsp_valid_ff && !rsp_ready)
   `ASSERT_CLK(a_write_after_pivot, ram_we |-> (found_ff && (cnt_ff >= pivot_ff)))
   `ASSERT_CLK(a_exh_beat_shape, (rsp_valid_ff && rsp_exhausted_ff) |-> rsp_last_ff)
   `ASSERT_CLK(a_emit_single_cycle, cmd.emit |=> !cmd.emit)
endmodule

FILE: src/next_combination_generator_unit.sv
// Top level of the lexicographic k-combination generator.
// Depends on ncg_pkg, ncg_ctrl and ncg_dpath.
//
// Usage:
//   csr_we/csr_index/csr_data write set_size (index 0) and subset_size (index 1)
//   while the block is idle; issue a request with restart set after a write.
//   Each request beat on req_valid/req_ready (payload req_restart) yields k
//   response beats on rsp_valid/rsp_ready, one element each in ascending
//   position, with rsp_last on the final one. With an invalid configuration
//   or after the last combination, a request yields one beat with
//   rsp_exhausted set.
// Sequencing:
//   An accepted request is checked, then the pivot scan runs 1 to k search
//   steps from the right, each a read and a compare, and then each element
//   is emitted as a registered read of the element RAM and an output beat.
//   req_ready is high only between requests; the combination advances
//   during emission.
// Reset and stall:
//   Reset loads 1..k, clears the exhausted state and sets n=5, k=3.
//   A stalled rsp_ready holds the output beat and pauses emission.
module next_combination_generator_unit
   import ncg_pkg::*;
#(
   parameter int MAX_K = 16,
   parameter int MAX_N = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [N_W-1:0]    rsp_element,
   output logic [POS_W-1:0]  rsp_position,
   output logic              rsp_last,
   output logic              rsp_final_combination,
   output logic              rsp_exhausted,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data
);
   cmd_type cmd;
   sts_type sts;

   ncg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .sts         (sts),
      .cmd         (cmd)
   );

   ncg_dpath #(
      .MAX_K (MAX_K),
      .MAX_N (MAX_N)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .cmd                   (cmd),
      .sts                   (sts),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_element           (rsp_element),
      .rsp_position          (rsp_position),
      .rsp_last              (rsp_last),
      .rsp_final_combination (rsp_final_combination),
      .rsp_exhausted         (rsp_exhausted)
   );
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for next_combination_generator_unit: predicts every element beat of each
// request and checks the responses under random idling. Depends on ncg_pkg and the RTL.
module tb_top;
   import ncg_pkg::*;

   localparam int COMB_SLOTS     = 16;
   localparam int RANDOM_TARGET  = 370;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      logic [N_W-1:0]   element;
      logic [POS_W-1:0] position;
      logic             last;
      logic             final_combination;
      logic             exhausted;
   } element_beat_type;

   typedef enum int {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_restart = 1'b0;
   logic              rsp_ready   = 1'b0;
   logic              csr_we      = 1'b0;
   logic [IDX_W-1:0]  csr_index   = REG_SET_SIZE;
   logic [CSR_W-1:0]  csr_data    = '0;
   logic              req_ready;
   logic              rsp_valid;
   logic [N_W-1:0]    rsp_element;
   logic [POS_W-1:0]  rsp_position;
   logic              rsp_last;
   logic              rsp_final_combination;
   logic              rsp_exhausted;

   // predictor state
   logic [N_W-1:0]    comb_state [COMB_SLOTS];
   logic              comb_done;
   logic [N_W-1:0]    cfg_n;
   logic [K_W-1:0]    cfg_k;
   element_beat_type  expected_elements [$];

   int requests_sent;
   int beats_checked;
   int finals_seen;
   int exhausted_seen;
   int configs_applied;
   int mismatch_count;
   int burst_left;
   int quiet_cycles;
   int hold_left;
   int stall_left;
   bit hold_request;
   rx_mode_type stall_mode;

   next_combination_generator_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_restart           (req_restart),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_element           (rsp_element),
      .rsp_position          (rsp_position),
      .rsp_last              (rsp_last),
      .rsp_final_combination (rsp_final_combination),
      .rsp_exhausted         (rsp_exhausted),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_combination(input logic restart);
      element_beat_type beat;
      int pivot;
      int lim;
      bit found;
      found = 1'b0;
      pivot = 0;
      if (restart) begin
         for (int i = 0; i < COMB_SLOTS; i++) comb_state[i] = N_W'(i + 1);
         comb_done = 1'b0;
      end
      if (cfg_k == '0 || int'(cfg_k) > COMB_SLOTS || int'(cfg_k) > int'(cfg_n) || comb_done) begin
         beat = '{element: '0, position: '0, last: 1'b1, final_combination: 1'b0,
                  exhausted: 1'b1};
         expected_elements = {expected_elements, beat};
         return;
      end
      // rightmost position still below its maximum
      for (int p = int'(cfg_k); p > 0; p--) begin
         lim = int'(cfg_n) - int'(cfg_k) + p;
         if (int'(comb_state[p-1]) < lim) begin
            found = 1'b1;
            pivot = p - 1;
            break;
         end
      end
      for (int p = 0; p < int'(cfg_k); p++) begin
         beat.element           = comb_state[p];
         beat.position          = p[POS_W-1:0];
         beat.last              = (p + 1 == int'(cfg_k));
         beat.final_combination = !found;
         beat.exhausted         = 1'b0;
         expected_elements = {expected_elements, beat};
      end
      if (!found) begin
         comb_done = 1'b1;
      end else begin
         comb_state[pivot] = comb_state[pivot] + 1'b1;
         for (int q = pivot + 1; q < int'(cfg_k); q++) comb_state[q] = comb_state[q-1] + 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: mismatch on %s: got %0d, expected %0d (beat %0d)",
                  $realtime, what, got, want, beats_checked);
      mismatch_count++;
   endtask

   // check every accepted response beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_elements.size() == 0) begin
            report_mismatch("unexpected beat", {2'b0, rsp_element}, 8'd0);
         end else begin
            element_beat_type want;
            want = expected_elements.pop_front();
            if (rsp_element !== want.element)
               report_mismatch("element", {2'b0, rsp_element}, {2'b0, want.element});
            if (rsp_position !== want.position)
               report_mismatch("position", {4'b0, rsp_position}, {4'b0, want.position});
            if (rsp_last !== want.last)
               report_mismatch("last", {7'b0, rsp_last}, {7'b0, want.last});
            if (rsp_final_combination !== want.final_combination)
               report_mismatch("final_combination", {7'b0, rsp_final_combination},
                               {7'b0, want.final_combination});
            if (rsp_exhausted !== want.exhausted)
               report_mismatch("exhausted", {7'b0, rsp_exhausted}, {7'b0, want.exhausted});
         end
         beats_checked++;
         if (rsp_final_combination === 1'b1 && rsp_last === 1'b1) finals_seen++;
         if (rsp_exhausted === 1'b1) exhausted_seen++;
      end
   end

   // receiver: long hold on request, otherwise changing stall patterns
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 60);
         end
         stall_left = stall_left - 1;
         case (stall_mode)
            RX_STREAM: rsp_ready <= 1'b1;
            RX_LIGHT:  rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  rsp_ready <= ($urandom_range(0, 2) == 0);
            default:   rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_request(input logic restart);
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      predict_combination(restart);
      requests_sent++;
   endtask

   // sender works in bursts with random gaps between them
   task automatic issue_request(input logic restart);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(restart);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_elements.size() != 0 || !req_ready);
   endtask

   task automatic apply_config(input bit wr_n, input logic [CSR_W-1:0] n_data,
                               input bit wr_k, input logic [CSR_W-1:0] k_data);
      if (wr_n) begin
         csr_we    <= 1'b1;
         csr_index <= REG_SET_SIZE;
         csr_data  <= n_data;
         @(posedge clock);
         cfg_n = n_data[N_W-1:0];
      end
      if (wr_k) begin
         csr_we    <= 1'b1;
         csr_index <= REG_SUBSET_SIZE;
         csr_data  <= k_data;
         @(posedge clock);
         cfg_k = k_data[K_W-1:0];
      end
      csr_we <= 1'b0;
      configs_applied++;
   endtask

   task automatic test_reset_state();
      issue_request(1'b0);
      issue_request(1'b0);
   endtask

   task automatic test_single_combination();
      wait_idle();
      apply_config(1'b1, 6'd3, 1'b1, 6'd3);
      issue_request(1'b1);
      issue_request(1'b0);
      issue_request(1'b0);
      issue_request(1'b1);
   endtask

   task automatic test_widest();
      wait_idle();
      apply_config(1'b1, 6'd63, 1'b1, 6'd16);
      issue_request(1'b1);
      issue_request(1'b0);
      issue_request(1'b0);
   endtask

   // config change without restart: the exhausted state stays until a restart
   task automatic test_stale_state();
      wait_idle();
      apply_config(1'b1, 6'd16, 1'b1, 6'd16);
      issue_request(1'b0);
      wait_idle();
      apply_config(1'b0, 6'd0, 1'b1, 6'd3);
      issue_request(1'b0);
      issue_request(1'b1);
   endtask

   task automatic test_smallest();
      wait_idle();
      apply_config(1'b1, 6'd1, 1'b1, 6'd1);
      issue_request(1'b1);
      issue_request(1'b0);
   endtask

   task automatic test_invalid_config();
      wait_idle();
      apply_config(1'b1, 6'd5, 1'b1, 6'd0);
      issue_request(1'b1);
      issue_request(1'b0);
      wait_idle();
      apply_config(1'b1, 6'd63, 1'b1, 6'd17);
      issue_request(1'b1);
      wait_idle();
      apply_config(1'b0, 6'd0, 1'b1, 6'h3F);
      issue_request(1'b0);
      wait_idle();
      apply_config(1'b1, 6'd4, 1'b1, 6'd5);
      issue_request(1'b1);
      wait_idle();
      apply_config(1'b1, 6'd0, 1'b1, 6'd1);
      issue_request(1'b1);
      wait_idle();
      apply_config(1'b1, 6'd10, 1'b1, 6'h22);
      issue_request(1'b1);
      issue_request(1'b0);
   endtask

   // walk a single element from 1 to 63, then one exhausted beat
   task automatic test_full_walk();
      wait_idle();
      apply_config(1'b1, 6'd63, 1'b1, 6'd1);
      issue_request(1'b1);
      repeat (63) issue_request(1'b0);
   endtask

   // hold the receiver off while requests keep coming, then drain
   task automatic test_backpressure();
      wait_idle();
      apply_config(1'b1, 6'd7, 1'b1, 6'd5);
      hold_request = 1'b1;
      issue_request(1'b1);
      repeat (5) issue_request(1'b0);
      wait_idle();
   endtask

   task automatic test_random_episodes();
      int n_val;
      int k_val;
      int len;
      int kind;
      bit fresh;
      bit k_msb;
      logic [CSR_W-1:0] k_data;
      while (requests_sent < RANDOM_TARGET) begin
         wait_idle();
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            n_val = $urandom_range(0, 63);
            k_val = $urandom_range(0, 31);
         end else begin
            n_val = (kind == 1) ? $urandom_range(13, 63) : $urandom_range(1, 9);
            k_val = $urandom_range(1, (n_val < COMB_SLOTS) ? n_val : COMB_SLOTS);
         end
         k_msb = $urandom_range(0, 1);
         k_data = {k_msb, k_val[4:0]};
         apply_config($urandom_range(0, 5) != 0, n_val[CSR_W-1:0],
                      $urandom_range(0, 5) != 0, k_data);
         fresh = ($urandom_range(0, 7) != 0);
         len = $urandom_range(2, 40);
         issue_request(fresh);
         repeat (len) issue_request($urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      cfg_n = SET_SIZE_RST;
      cfg_k = SUBSET_SIZE_RST;
      comb_done = 1'b0;
      for (int i = 0; i < COMB_SLOTS; i++) comb_state[i] = N_W'(i + 1);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_single_combination();
      test_widest();
      test_stale_state();
      test_smallest();
      test_invalid_config();
      test_full_walk();
      test_backpressure();
      test_random_episodes();

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests over %0d register settings, %0d element beats checked",
               requests_sent, configs_applied, beats_checked);
      $display("Saw %0d final combinations, %0d exhausted replies, %0d mismatches",
               finals_seen, exhausted_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/ncg_pkg.sv
src/ncg_ram.sv
src/ncg_ctrl.sv
src/ncg_dpath.sv
src/next_combination_generator_unit.sv
sim/tb_top.sv
